[hw/rtl/pso_pkg.sv]
package pso_pkg;

    // Store, table and phase geometry
    localparam int STRING_DEPTH = 2048;
    localparam int SINE_ENTRIES = 256;
    localparam int PHASE_BITS   = 24;

    localparam int IDX_W     = $clog2(STRING_DEPTH);
    localparam int LEN_W     = $clog2(STRING_DEPTH + 1);
    localparam int SINE_BITS = $clog2(SINE_ENTRIES);

    // Register file geometry
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 24;
    localparam int WAVE_W     = 3;
    localparam int STRLEN_W   = 12;

    localparam logic [CFG_ADDR_W-1:0] REG_WAVEFORM   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PHASE_INC  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_STRING_LEN = 2'd2;

    localparam logic [WAVE_W-1:0] WAVE_SINE     = 3'd0;
    localparam logic [WAVE_W-1:0] WAVE_SQUARE   = 3'd1;
    localparam logic [WAVE_W-1:0] WAVE_SAW      = 3'd2;
    localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 3'd3;
    localparam logic [WAVE_W-1:0] WAVE_STRING   = 3'd4;

    localparam logic FUNC_TICK   = 1'b0;
    localparam logic FUNC_EXCITE = 1'b1;

    // Damping and noise constants
    localparam logic [15:0]        DAMP_RESET = 16'd65405;
    localparam logic signed [18:0] DAMP_BASE  = 19'sd65405;
    localparam logic signed [18:0] DAMP_MIN   = 19'sd64553;
    localparam logic signed [18:0] DAMP_MAX   = 19'sd65503;
    localparam logic signed [7:0]  NOTE_MID   = 8'sd60;
    localparam logic signed [14:0] NOTE_SLOPE = 15'sd13981;
    localparam logic [31:0]        LCG_MUL    = 32'd1664525;
    localparam logic [31:0]        LCG_ADD    = 32'd1013904223;
    localparam logic [31:0]        LCG_SEED   = 32'd1;
    localparam logic signed [16:0] NOISE_GAIN = 17'sd26214;

    typedef longint unsigned u64_t;

    localparam u64_t HALF_PI_Q30 = 64'd1686629713;

    // One write into the string store
    typedef struct packed {
        logic                    en;
        logic [IDX_W-1:0]        addr;
        logic signed [15:0]      data;
    } mem_wr_t;

    // One step of a fill or clearing sweep
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] addr;
        logic             noise;
    } sweep_issue_t;

    typedef logic [15:0] sine_table_t [0:SINE_ENTRIES];

    // Quarter-wave sine in Q1.15, Taylor series to the x^15 term in Q30
    function automatic sine_table_t build_sine();
        sine_table_t       t;
        u64_t              a;
        u64_t              a2;
        u64_t              term;
        longint            sum;
        longint            q;
        for (int m = 0; m <= SINE_ENTRIES; m++) begin
            a    = (u64_t'(m) * HALF_PI_Q30) >> SINE_BITS;
            a2   = (a * a) >> 30;
            term = a;
            sum  = longint'(a);
            // Odd terms x^3 .. x^15 with alternating sign
            term = ((term * a2) >> 30) / 64'd6;
            sum  = sum - longint'(term);
            term = ((term * a2) >> 30) / 64'd20;
            sum  = sum + longint'(term);
            term = ((term * a2) >> 30) / 64'd42;
            sum  = sum - longint'(term);
            term = ((term * a2) >> 30) / 64'd72;
            sum  = sum + longint'(term);
            term = ((term * a2) >> 30) / 64'd110;
            sum  = sum - longint'(term);
            term = ((term * a2) >> 30) / 64'd156;
            sum  = sum + longint'(term);
            term = ((term * a2) >> 30) / 64'd210;
            sum  = sum - longint'(term);
            q = (sum > 0) ? ((sum + 64'sd16384) >>> 15) : 64'sd0;
            if (q > 64'sd32767) begin
                q = 64'sd32767;
            end
            t[m] = 16'(q);
        end
        return t;
    endfunction

    localparam sine_table_t SINE_TABLE = build_sine();

endpackage

[hw/rtl/phase_and_plucked_string_oscillator.sv]
// Audio oscillator: phase-accumulator waveforms and a plucked-string delay line.
// Input stream (s_): s_tuser selects the operation (0 tick, 1 excite) and
// s_tdata carries the MIDI note for an excite. A tick returns one signed
// Q1.15 sample on the output stream (m_tdata); an excite returns nothing.
// Configuration: cfg_we writes cfg_wdata into register cfg_addr (0 waveform,
// 1 phase increment, 2 string length); write only while the block is idle.
// A tick's two store reads are registered at its transfer, and its sample
// enters the output register from the TICK state; no new item is taken
// until the tick leaves TICK, as each one reads two entries of the string
// store and writes one back on its single write port. An excite sweeps the
// whole store, one entry per cycle, and input waits until its last write lands.
// Reset: a clearing pass zeroes the string store, during which s_tready
// stays low.
// Stall: a new item is taken while a sample waits in the output register;
// the following tick then holds in its final stage, and with it the store
// write-back, until m_tready frees the register.
module phase_and_plucked_string_oscillator (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,  // [6:0] note, [7] zero
    input  logic                             s_tuser,  // [0] func
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [15:0]                      m_tdata,  // [15:0] sample
    input  logic                             cfg_we,
    input  logic [pso_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [pso_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import pso_pkg::*;

    typedef enum logic [2:0] {
        ST_SWEEP = 3'b001,
        ST_IDLE  = 3'b010,
        ST_TICK  = 3'b100
    } state_t;

    state_t                st_reg, st_next;
    logic [WAVE_W-1:0]     waveform_reg, waveform_next;
    logic [PHASE_BITS-1:0] phase_inc_reg, phase_inc_next;
    logic [STRLEN_W-1:0]   str_len_reg, str_len_next;
    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic [IDX_W-1:0]      read_index_reg, read_index_next;
    logic [15:0]           damping_reg, damping_next;
    logic [LEN_W-1:0]      sweep_idx_reg, sweep_idx_next;
    logic [LEN_W-1:0]      sweep_len_reg, sweep_len_next;
    logic                  m_valid_reg, m_valid_next;
    logic signed [15:0]    m_data_reg, m_data_next;
    logic [PHASE_BITS-1:0] tick_phase_reg;
    logic [IDX_W-1:0]      tick_index_reg;
    logic                  tick_string_reg;

    logic                  s_xfer;
    logic                  tick_done;
    logic [LEN_W-1:0]      act_len;
    logic [IDX_W-1:0]      idx_i;
    logic [IDX_W-1:0]      idx_j;
    logic [LEN_W-1:0]      idx_i_inc;

    logic signed [15:0]    rd_a;
    logic signed [15:0]    rd_b;
    logic signed [16:0]    pair_sum;
    logic signed [33:0]    damped;
    logic signed [15:0]    wave_sample;

    logic signed [7:0]     note_diff;
    logic signed [22:0]    note_prod;
    logic signed [22:0]    note_shift;
    logic signed [18:0]    damp_raw;

    sweep_issue_t          issue;
    mem_wr_t               noise_wr;
    mem_wr_t               tick_wr;
    mem_wr_t               mem_wr;

    // Accept only when idle and the last sweep write has landed
    assign s_tready  = (st_reg == ST_IDLE) && !noise_wr.en;
    assign s_xfer    = s_tvalid && s_tready;
    assign tick_done = (st_reg == ST_TICK) && (!m_valid_reg || m_tready);

    // Clamp the active string length into 1..STRING_DEPTH
    always_comb begin
        if (str_len_reg == '0) begin
            act_len = LEN_W'(1);
        end else if (32'(str_len_reg) > 32'(STRING_DEPTH)) begin
            act_len = LEN_W'(STRING_DEPTH);
        end else begin
            act_len = LEN_W'(str_len_reg);
        end
    end

    // Current entry and its successor, wrapping at the active length
    always_comb begin
        idx_i     = (32'(read_index_reg) < 32'(STRING_DEPTH)) ? read_index_reg : '0;
        idx_i_inc = LEN_W'(idx_i) + LEN_W'(1);
        idx_j     = (idx_i_inc < act_len) ? idx_i_inc[IDX_W-1:0] : '0;
    end

    // Damping from the note, clamped
    always_comb begin
        note_diff  = $signed({1'b0, s_tdata[6:0]}) - NOTE_MID;
        note_prod  = note_diff * NOTE_SLOPE;
        note_shift = note_prod >>> 10;
        damp_raw   = DAMP_BASE - 19'(note_shift);
        if (damp_raw < DAMP_MIN) begin
            damp_raw = DAMP_MIN;
        end else if (damp_raw > DAMP_MAX) begin
            damp_raw = DAMP_MAX;
        end
    end

    // Damped average of the pair read for the tick
    assign pair_sum = 17'(rd_a) + 17'(rd_b);
    assign damped   = $signed({1'b0, damping_reg}) * pair_sum;

    always_comb begin
        tick_wr.en   = tick_done && tick_string_reg;
        tick_wr.addr = tick_index_reg;
        tick_wr.data = damped[32:17];
        mem_wr       = noise_wr.en ? noise_wr : tick_wr;
    end

    // Sweep step: noise below the length, zero above
    always_comb begin
        issue.valid = (st_reg == ST_SWEEP);
        issue.addr  = sweep_idx_reg[IDX_W-1:0];
        issue.noise = (sweep_idx_reg < sweep_len_reg);
    end

    // Configuration writes
    always_comb begin
        waveform_next  = waveform_reg;
        phase_inc_next = phase_inc_reg;
        str_len_next   = str_len_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                REG_WAVEFORM:   waveform_next  = cfg_wdata[WAVE_W-1:0];
                REG_PHASE_INC:  phase_inc_next = PHASE_BITS'(cfg_wdata);
                REG_STRING_LEN: str_len_next   = cfg_wdata[STRLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer
    always_comb begin
        st_next         = st_reg;
        phase_next      = phase_reg;
        read_index_next = read_index_reg;
        damping_next    = damping_reg;
        sweep_idx_next  = sweep_idx_reg;
        sweep_len_next  = sweep_len_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        unique case (st_reg)
            ST_SWEEP: begin
                if (sweep_idx_reg == LEN_W'(STRING_DEPTH - 1)) begin
                    st_next = ST_IDLE;
                end else begin
                    sweep_idx_next = sweep_idx_reg + LEN_W'(1);
                end
            end
            ST_IDLE: begin
                if (s_xfer) begin
                    if (s_tuser == FUNC_EXCITE) begin
                        damping_next    = damp_raw[15:0];
                        sweep_len_next  = act_len;
                        sweep_idx_next  = '0;
                        read_index_next = '0;
                        st_next         = ST_SWEEP;
                    end else begin
                        if (waveform_reg == WAVE_STRING) begin
                            read_index_next = idx_j;
                        end else begin
                            phase_next = phase_reg + phase_inc_reg;
                        end
                        st_next = ST_TICK;
                    end
                end
            end
            default: begin
                if (tick_done) begin
                    m_valid_next = 1'b1;
                    m_data_next  = tick_string_reg ? rd_a : wave_sample;
                    st_next      = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg         <= ST_SWEEP;
            waveform_reg   <= WAVE_SINE;
            phase_inc_reg  <= '0;
            str_len_reg    <= STRLEN_W'(1);
            phase_reg      <= '0;
            read_index_reg <= '0;
            damping_reg    <= DAMP_RESET;
            sweep_idx_reg  <= '0;
            sweep_len_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            st_reg         <= st_next;
            waveform_reg   <= waveform_next;
            phase_inc_reg  <= phase_inc_next;
            str_len_reg    <= str_len_next;
            phase_reg      <= phase_next;
            read_index_reg <= read_index_next;
            damping_reg    <= damping_next;
            sweep_idx_reg  <= sweep_idx_next;
            sweep_len_reg  <= sweep_len_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Hold the tick's operands and the output sample
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (s_xfer) begin
            tick_phase_reg  <= phase_reg;
            tick_index_reg  <= idx_i;
            tick_string_reg <= (waveform_reg == WAVE_STRING);
        end
    end

    pso_string_mem u_mem (
        .aclk      (aclk),
        .rd_en     (s_xfer),
        .rd_addr_a (idx_i),
        .rd_addr_b (idx_j),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b),
        .wr        (mem_wr)
    );

    pso_noise u_noise (
        .aclk    (aclk),
        .aresetn (aresetn),
        .issue   (issue),
        .wr      (noise_wr)
    );

    pso_wave u_wave (
        .waveform (waveform_reg),
        .phase    (tick_phase_reg),
        .sample   (wave_sample)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

[hw/rtl/pso_string_mem.sv]
module pso_string_mem (
    input  logic                    aclk,
    input  logic                    rd_en,
    input  logic [pso_pkg::IDX_W-1:0] rd_addr_a,
    input  logic [pso_pkg::IDX_W-1:0] rd_addr_b,
    output logic signed [15:0]      rd_data_a,
    output logic signed [15:0]      rd_data_b,
    input  pso_pkg::mem_wr_t        wr
);
    import pso_pkg::*;

    logic signed [15:0] mem [STRING_DEPTH];
    logic signed [15:0] rd_data_a_reg;
    logic signed [15:0] rd_data_b_reg;

    // Write one entry, read two with registered data
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en) begin
            rd_data_a_reg <= mem[rd_addr_a];
            rd_data_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

[hw/rtl/pso_noise.sv]
module pso_noise (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  pso_pkg::sweep_issue_t issue,
    output pso_pkg::mem_wr_t      wr
);
    import pso_pkg::*;

    logic [31:0]      rng_reg;
    logic [31:0]      rng_next;
    logic             pend_reg;
    logic [IDX_W-1:0] addr_reg;
    logic             noise_reg;

    logic signed [15:0] centred;
    logic signed [32:0] scaled;

    // Advance the generator once per noise entry
    always_comb begin
        rng_next = rng_reg;
        if (issue.valid && issue.noise) begin
            rng_next = rng_reg * LCG_MUL + LCG_ADD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rng_reg  <= LCG_SEED;
            pend_reg <= 1'b0;
        end else begin
            rng_reg  <= rng_next;
            pend_reg <= issue.valid;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg  <= issue.addr;
        noise_reg <= issue.noise;
    end

    // Centre bits 23..8 and scale by 0.8, floor shift
    assign centred = $signed({~rng_reg[23], rng_reg[22:8]});
    assign scaled  = centred * NOISE_GAIN;

    always_comb begin
        wr.en   = pend_reg;
        wr.addr = addr_reg;
        wr.data = noise_reg ? scaled[30:15] : 16'sd0;
    end

endmodule

[hw/rtl/pso_wave.sv]
module pso_wave (
    input  logic [pso_pkg::WAVE_W-1:0]     waveform,
    input  logic [pso_pkg::PHASE_BITS-1:0] phase,
    output logic signed [15:0]             sample
);
    import pso_pkg::*;

    logic [SINE_BITS+1:0] sidx;
    logic [1:0]           quad;
    logic [SINE_BITS-1:0] k;
    logic [SINE_BITS:0]   k_rev;
    logic signed [15:0]   t_fwd;
    logic signed [15:0]   t_rev;
    logic signed [15:0]   sine;
    logic signed [15:0]   saw;
    logic signed [17:0]   tri_full;
    logic signed [15:0]   tri_sat;

    // Quarter-wave table lookup with mirroring and sign per quadrant
    assign sidx  = phase[PHASE_BITS-1 -: SINE_BITS+2];
    assign quad  = sidx[SINE_BITS+1:SINE_BITS];
    assign k     = sidx[SINE_BITS-1:0];
    assign k_rev = (SINE_BITS+1)'(SINE_ENTRIES) - {1'b0, k};
    assign t_fwd = $signed(SINE_TABLE[{1'b0, k}]);
    assign t_rev = $signed(SINE_TABLE[k_rev]);

    always_comb begin
        unique case (quad)
            2'd0:    sine = t_fwd;
            2'd1:    sine = t_rev;
            2'd2:    sine = -t_fwd;
            default: sine = -t_rev;
        endcase
    end

    // Saw is the top sixteen phase bits, offset to signed
    assign saw = $signed({~phase[PHASE_BITS-1], phase[PHASE_BITS-2 -: 15]});

    // Triangle folds the saw, saturating at the top
    always_comb begin
        tri_full = (saw < 0) ? -18'(saw) : 18'(saw);
        tri_full = (tri_full <<< 1) - 18'sd32768;
        tri_sat  = (tri_full > 18'sd32767) ? 16'sd32767 : tri_full[15:0];
    end

    always_comb begin
        unique case (waveform)
            WAVE_SINE:     sample = sine;
            WAVE_SQUARE:   sample = phase[PHASE_BITS-1] ? -16'sd32768 : 16'sd32767;
            WAVE_SAW:      sample = saw;
            WAVE_TRIANGLE: sample = tri_sat;
            default:       sample = 16'sd0;
        endcase
    end

endmodule

[dv/tb.sv]
module tb;
    import pso_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int QUIET_LIMIT = 20000;
    localparam int SWEEP_WAIT  = STRING_DEPTH + 52;
    localparam int RANDOM_ITEMS = 1700;

    // Index past the register file, must be ignored
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 2'd3;

    typedef struct {
        logic       func;
        logic [6:0] note;
    } osc_item_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [15:0]           m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    phase_and_plucked_string_oscillator u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #CLK_HALF aclk = ~aclk;

    // Shadow registers and oscillator state
    logic [WAVE_W-1:0]     cfg_wave = WAVE_SINE;
    logic [PHASE_BITS-1:0] cfg_inc  = '0;
    logic [STRLEN_W-1:0]   cfg_len  = 12'd1;

    logic [PHASE_BITS-1:0] osc_phase = '0;
    logic signed [15:0]    str_mem [0:STRING_DEPTH-1];
    logic [IDX_W-1:0]      rd_idx   = '0;
    logic [15:0]           damp     = DAMP_RESET;
    logic [31:0]           lcg      = LCG_SEED;
    logic [15:0]           sine_q15 [0:SINE_ENTRIES];

    osc_item_t   pend_items [$];
    logic [15:0] exp_samples [$];
    int          n_samples = 0;
    int          n_errors  = 0;

    int burst_left = 0;
    int gap_left   = 0;
    int hold_left  = 0;
    int next_hold  = 200;
    int rx_mode    = 0;
    int rx_cyc     = 0;
    int quiet      = 0;

    // Quarter-wave entry m: Taylor series in Q30, rounded to Q1.15
    function automatic logic [15:0] quarter_sine_q15(input int m);
        longint unsigned ang;
        longint unsigned ang2;
        longint unsigned trm;
        longint          acc;
        longint          r;
        ang  = (u64_t'(m) * HALF_PI_Q30) / SINE_ENTRIES;
        ang2 = (ang * ang) >> 30;
        trm  = ang;
        acc  = longint'(ang);
        for (int n = 1; n <= 7; n++) begin
            trm = ((trm * ang2) >> 30) / u64_t'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                acc = acc - longint'(trm);
            end else begin
                acc = acc + longint'(trm);
            end
        end
        r = (acc > 0) ? ((acc + 64'sd16384) >>> 15) : 64'sd0;
        if (r > 64'sd32767) begin
            r = 64'sd32767;
        end
        return 16'(r);
    endfunction

    // Length 0 behaves as 1, anything past the store as the full store
    function automatic int active_len();
        if (cfg_len == 0) begin
            return 1;
        end
        if (int'(cfg_len) > STRING_DEPTH) begin
            return STRING_DEPTH;
        end
        return int'(cfg_len);
    endfunction

    // Advance the oscillator by one transfer and queue the sample it yields
    task automatic step_oscillator(input logic func, input logic [6:0] note);
        logic [PHASE_BITS-1:0] p;
        logic [9:0]            sidx;
        int                    k;
        int                    saw;
        int                    mag;
        int                    v;
        int                    len;
        int                    i;
        int                    j;
        int                    nn;
        int                    nv;
        longint                d;
        longint                acc;
        if (func == FUNC_EXCITE) begin
            nn = note;
            d  = 64'sd65405 - (((longint'(nn) - 64'sd60) * 64'sd13981) >>> 10);
            if (d < 64'sd64553) d = 64'sd64553;
            if (d > 64'sd65503) d = 64'sd65503;
            damp = 16'(d);
            len  = active_len();
            for (i = 0; i < STRING_DEPTH; i++) begin
                if (i < len) begin
                    lcg        = lcg * LCG_MUL + LCG_ADD;
                    nv         = lcg[23:8];
                    nv         = nv - 32768;
                    str_mem[i] = 16'((nv * 26214) >>> 15);
                end else begin
                    str_mem[i] = '0;
                end
            end
            rd_idx = '0;
        end else begin
            if (cfg_wave == WAVE_STRING) begin
                len = active_len();
                i   = rd_idx;
                j   = (i + 1 < len) ? i + 1 : 0;
                v   = str_mem[i];
                acc = longint'(damp) * (longint'(str_mem[i]) + longint'(str_mem[j]));
                str_mem[i] = 16'(acc >>> 17);
                rd_idx = IDX_W'(j);
            end else begin
                p         = osc_phase;
                osc_phase = p + cfg_inc;
                saw       = p[PHASE_BITS-1 -: 16];
                saw       = saw - 32768;
                case (cfg_wave)
                    WAVE_SINE: begin
                        sidx = p[PHASE_BITS-1 -: 10];
                        k    = sidx[7:0];
                        case (sidx[9:8])
                            2'd0: v = sine_q15[k];
                            2'd1: v = sine_q15[SINE_ENTRIES - k];
                            2'd2: v = -int'(sine_q15[k]);
                            default: v = -int'(sine_q15[SINE_ENTRIES - k]);
                        endcase
                    end
                    WAVE_SQUARE: begin
                        v = (p < (1 << (PHASE_BITS - 1))) ? 32767 : -32768;
                    end
                    WAVE_SAW: begin
                        v = saw;
                    end
                    WAVE_TRIANGLE: begin
                        mag = (saw < 0) ? -saw : saw;
                        v   = 2 * mag - 32768;
                        if (v > 32767) v = 32767;
                    end
                    default: begin
                        v = 0;
                    end
                endcase
            end
            exp_samples.push_back(16'(v));
        end
    endtask

    // Write one register at an edge and mirror it in the shadow copy
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_WAVEFORM:   cfg_wave = val[WAVE_W-1:0];
            REG_PHASE_INC:  cfg_inc  = val[PHASE_BITS-1:0];
            REG_STRING_LEN: cfg_len  = val[STRLEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_voice(input logic [WAVE_W-1:0] wave,
                             input logic [PHASE_BITS-1:0] inc,
                             input logic [STRLEN_W-1:0] len);
        write_reg(REG_WAVEFORM, wave);
        write_reg(REG_PHASE_INC, inc);
        write_reg(REG_STRING_LEN, len);
    endtask

    task automatic push_item(input logic func, input logic [6:0] note);
        osc_item_t it;
        it.func = func;
        it.note = note;
        pend_items.push_back(it);
    endtask

    // Wait for every transfer and sample, then let an excite sweep finish
    task automatic settle();
        while (pend_items.size() != 0 || exp_samples.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SWEEP_WAIT) @(posedge aclk);
    endtask

    // Reset
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Stimulus: directed cases, then random voices
    initial begin
        logic [WAVE_W-1:0]     wave;
        logic [PHASE_BITS-1:0] inc;
        logic [STRLEN_W-1:0]   len;
        int                    n;
        int                    r;
        int                    exc_pct;
        int                    n_random;
        for (int m = 0; m <= SINE_ENTRIES; m++) begin
            sine_q15[m] = quarter_sine_q15(m);
        end
        for (int m = 0; m < STRING_DEPTH; m++) begin
            str_mem[m] = '0;
        end
        wait (aresetn);

        // Sine at quarter steps: each quadrant from its start, so both ends of the table are read
        write_reg(REG_SPARE, 24'hFFFFFF);
        set_voice(WAVE_SINE, 24'h400000, 12'd1);
        repeat (4) push_item(FUNC_TICK, 7'($urandom));
        settle();
        set_voice(WAVE_SQUARE, 24'h800000, 12'd1);
        repeat (2) push_item(FUNC_TICK, 7'($urandom));
        settle();
        set_voice(WAVE_SAW, 24'hFFFFFF, 12'd1);
        repeat (2) push_item(FUNC_TICK, 7'($urandom));
        settle();
        // Triangle from phase zero hits the positive saturation
        write_reg(REG_PHASE_INC, 24'h000002);
        push_item(FUNC_TICK, 7'd0);
        settle();
        set_voice(WAVE_TRIANGLE, 24'h400000, 12'd1);
        repeat (2) push_item(FUNC_TICK, 7'($urandom));
        settle();
        // Unused codes give silence but keep the phase moving
        for (int w = WAVE_STRING + 1; w < 8; w++) begin
            set_voice(WAVE_W'(w), 24'h123457, 12'd1);
            push_item(FUNC_TICK, 7'($urandom));
            settle();
        end
        // Zero and oversized lengths, lowest and highest notes
        set_voice(WAVE_STRING, 24'h000000, 12'd0);
        push_item(FUNC_EXCITE, 7'd0);
        push_item(FUNC_TICK, 7'd0);
        settle();
        set_voice(WAVE_STRING, 24'h000000, 12'd4095);
        push_item(FUNC_EXCITE, 7'd127);
        push_item(FUNC_TICK, 7'd127);
        settle();
        set_voice(WAVE_STRING, 24'h000000, 12'd12);
        push_item(FUNC_EXCITE, 7'd60);
        repeat (6) push_item(FUNC_TICK, 7'($urandom));
        settle();
        // Shrink the string under the read index
        set_voice(WAVE_STRING, 24'h000000, 12'd3);
        repeat (2) push_item(FUNC_TICK, 7'($urandom));
        settle();

        // Random voices, many of them plucked strings, mostly of short length
        n_random = 0;
        while (n_random < RANDOM_ITEMS) begin
            wave = ($urandom_range(0, 9) < 4) ? WAVE_STRING : WAVE_W'($urandom_range(0, 7));
            case ($urandom_range(0, 7))
                0: inc = '0;
                1: inc = '1;
                2: inc = PHASE_BITS'($urandom_range(1, 255));
                default: inc = PHASE_BITS'($urandom);
            endcase
            r = $urandom_range(0, 19);
            if (r < 14) begin
                len = STRLEN_W'($urandom_range(1, 40));
            end else if (r < 16) begin
                len = STRLEN_W'($urandom_range(41, STRING_DEPTH));
            end else if (r == 16) begin
                len = STRLEN_W'(STRING_DEPTH);
            end else if (r == 17) begin
                len = '0;
            end else begin
                len = STRLEN_W'($urandom_range(STRING_DEPTH + 1, 4095));
            end
            set_voice(wave, inc, len);
            n = $urandom_range(10, 60);
            exc_pct = (wave == WAVE_STRING) ? 4 : 2;
            if (wave == WAVE_STRING && $urandom_range(0, 9) < 8) begin
                push_item(FUNC_EXCITE, 7'($urandom));
                n_random++;
            end
            repeat (n) begin
                push_item(($urandom_range(0, 99) < exc_pct) ? FUNC_EXCITE : FUNC_TICK,
                          7'($urandom));
            end
            n_random += n;
            settle();
        end

        if (n_errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    // Driver: offer queued items in bursts, hold each until its transfer
    always @(posedge aclk) begin
        logic offer;
        offer = 1'b0;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                step_oscillator(pend_items[0].func, pend_items[0].note);
                void'(pend_items.pop_front());
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
                end
            end
            if (s_tvalid && !s_tready) begin
                offer = 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
            end else if (pend_items.size() > 0) begin
                offer = 1'b1;
            end
            s_tvalid <= offer;
            if (offer) begin
                s_tdata <= {1'b0, pend_items[0].note};
                s_tuser <= pend_items[0].func;
            end
        end
    end

    // Receiver: shifting stall patterns, with a long hold-off now and then
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (n_samples >= next_hold && pend_items.size() > 16 &&
                     pend_items[0].func == FUNC_TICK) begin
            hold_left = 300;
            next_hold = n_samples + 700;
            m_tready <= 1'b0;
        end else begin
            if (rx_cyc % 64 == 0) rx_mode = $urandom_range(0, 3);
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 1) == 1);
                2: m_tready <= (rx_cyc % 4 != 0);
                default: m_tready <= ($urandom_range(0, 4) == 0);
            endcase
        end
        rx_cyc++;
    end

    // Monitor: compare each sample transfer with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (exp_samples.size() == 0) begin
                n_errors++;
                $display("%0t: sample with nothing pending: expected none, actual %0d",
                         $time, $signed(m_tdata));
            end else begin
                if (m_tdata !== exp_samples[0]) begin
                    n_errors++;
                    $display("%0t: sample mismatch: expected %0d, actual %0d",
                             $time, $signed(exp_samples[0]), $signed(m_tdata));
                end
                void'(exp_samples.pop_front());
            end
            n_samples++;
        end
    end

    // Watchdog: stop when no transfer happens for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("tb: errors");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

endmodule

[files.f]
hw/rtl/pso_pkg.sv
hw/rtl/pso_string_mem.sv
hw/rtl/pso_noise.sv
hw/rtl/pso_wave.sv
hw/rtl/phase_and_plucked_string_oscillator.sv
dv/tb.sv
